@@ sv/svx_pkg.sv @@
// Shared types and constants for the script execute unit.
// No dependencies; imported by the execute unit top level.
`default_nettype none

package svx_pkg;

  localparam int NUM_VARS  = 256;
  localparam int VAR_AW    = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int PC_WIDTH  = 16;
  localparam int VAR_WIDTH = 32;
  localparam int IDX_WIDTH = 8;
  localparam int TGT_WIDTH = 16;
  localparam int LEN_WIDTH = 16;
  localparam int ACT_WIDTH = 4;

  typedef enum logic [ACT_WIDTH-1:0] {
    ACT_JMP  = 4'd0,
    ACT_JEQ  = 4'd1,
    ACT_JNE  = 4'd2,
    ACT_JLT  = 4'd3,
    ACT_JLE  = 4'd4,
    ACT_JGT  = 4'd5,
    ACT_JGE  = 4'd6,
    ACT_SET  = 4'd7,
    ACT_ADD  = 4'd8,
    ACT_SUB  = 4'd9,
    ACT_MOVE = 4'd10,
    ACT_END  = 4'd11
  } act_t;

  // Instruction held in the execute stage while its operands come out of the RAM.
  typedef struct packed {
    logic [ACT_WIDTH-1:0] action;
    logic [PC_WIDTH-1:0]  target;
    logic [VAR_WIDTH-1:0] cval;
    logic [IDX_WIDTH-1:0] rd_a;
    logic [IDX_WIDTH-1:0] rd_b;
    logic [IDX_WIDTH-1:0] dst;
  } exe_instr_t;

endpackage

`default_nettype wire

@@ sv/svx_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; instanced twice by the execute unit for its variable file.
`default_nettype none

module svx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic                                re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/script_vm_execute_unit.sv @@
// An accepted word is held in the execute-stage register; its result goes to the output register
// when that stage fires, which waits while the output register holds a result not yet taken.
// One instruction per cycle unless the output stalls; operand reads go to two copies of the
// variable RAM and the value written by the previous instruction is forwarded around the RAM.
// Reset (rst_n low, synchronous) clears the pc, program length, output and per-entry valid
// bits; an entry never written reads as zero, so no clearing pass is needed.
`default_nettype none

module script_vm_execute_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [svx_pkg::LEN_WIDTH-1:0]   cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [svx_pkg::ACT_WIDTH-1:0]   in_action,
  input  wire logic [svx_pkg::TGT_WIDTH-1:0]   in_jump_target,
  input  wire logic [svx_pkg::IDX_WIDTH-1:0]   in_test_index,
  input  wire logic signed [svx_pkg::VAR_WIDTH-1:0] in_constant_value,
  input  wire logic [svx_pkg::IDX_WIDTH-1:0]   in_source_a,
  input  wire logic [svx_pkg::IDX_WIDTH-1:0]   in_source_b,
  input  wire logic [svx_pkg::IDX_WIDTH-1:0]   in_dest_index,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [15:0]                          out_next_pc,
  output logic                                 out_done_res,
  output logic                                 out_taken,
  output logic signed [svx_pkg::VAR_WIDTH-1:0] out_written_value
);

  import svx_pkg::*;

  logic [LEN_WIDTH-1:0] prog_len_r;
  logic [PC_WIDTH-1:0]  pc_r, pc_nxt;
  logic                 s1_vld_r;
  exe_instr_t           s1_r, s1_nxt;
  logic                 s1_fire, in_fire;
  logic                 is_jump_in;

  logic [NUM_VARS-1:0]  vld_r;
  logic                 fwd_vld_r;
  logic [IDX_WIDTH-1:0] fwd_idx_r;
  logic [VAR_WIDTH-1:0] fwd_data_r;

  logic [VAR_WIDTH-1:0] ram_a, ram_b, op_a, op_b;
  logic [VAR_WIDTH-1:0] wval;
  logic                 wr, take, ended, neg, zero;
  logic                 wr_en, dst_in_range, a_in_range, b_in_range;
  logic [VAR_AW-1:0]    waddr, raddr_a, raddr_b;
  logic [31:0]          npc_ext;

  logic                 out_vld_r;
  logic [15:0]          out_pc_r;
  logic                 out_done_r, out_taken_r;
  logic [VAR_WIDTH-1:0] out_wval_r;

  // ---------------------------------------------------------------- accept
  assign s1_fire  = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign is_jump_in = in_action inside {[ACT_JMP:ACT_JGE]};

  always_comb begin
    s1_nxt.action = in_action;
    s1_nxt.target = PC_WIDTH'(in_jump_target);
    s1_nxt.cval   = in_constant_value;
    // Jumps only need the tested variable, so it shares the first read port.
    s1_nxt.rd_a   = is_jump_in ? in_test_index : in_source_a;
    s1_nxt.rd_b   = in_source_b;
    s1_nxt.dst    = in_dest_index;
  end

  assign raddr_a = s1_nxt.rd_a[VAR_AW-1:0];
  assign raddr_b = s1_nxt.rd_b[VAR_AW-1:0];

  svx_ram #(.WIDTH(VAR_WIDTH), .DEPTH(NUM_VARS)) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wval),
    .re    (in_fire),
    .raddr (raddr_a),
    .rdata (ram_a)
  );

  svx_ram #(.WIDTH(VAR_WIDTH), .DEPTH(NUM_VARS)) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wval),
    .re    (in_fire),
    .raddr (raddr_b),
    .rdata (ram_b)
  );

  // --------------------------------------------------------------- execute
  assign a_in_range   = 32'(s1_r.rd_a) < NUM_VARS;
  assign b_in_range   = 32'(s1_r.rd_b) < NUM_VARS;
  assign dst_in_range = 32'(s1_r.dst) < NUM_VARS;

  // The most recent write is forwarded, since it may have landed at the edge of the read.
  always_comb begin
    if (!a_in_range) begin
      op_a = '0;
    end else if (fwd_vld_r && fwd_idx_r == s1_r.rd_a) begin
      op_a = fwd_data_r;
    end else if (vld_r[s1_r.rd_a[VAR_AW-1:0]]) begin
      op_a = ram_a;
    end else begin
      op_a = '0;
    end
    if (!b_in_range) begin
      op_b = '0;
    end else if (fwd_vld_r && fwd_idx_r == s1_r.rd_b) begin
      op_b = fwd_data_r;
    end else if (vld_r[s1_r.rd_b[VAR_AW-1:0]]) begin
      op_b = ram_b;
    end else begin
      op_b = '0;
    end
  end

  assign neg  = op_a[VAR_WIDTH-1];
  assign zero = (op_a == '0);

  always_comb begin
    take  = 1'b0;
    ended = 1'b0;
    wr    = 1'b0;
    wval  = '0;
    case (s1_r.action)
      ACT_JMP:  take = 1'b1;
      ACT_JEQ:  take = zero;
      ACT_JNE:  take = !zero;
      ACT_JLT:  take = neg;
      ACT_JLE:  take = neg || zero;
      ACT_JGT:  take = !neg && !zero;
      ACT_JGE:  take = !neg;
      ACT_SET:  begin wval = s1_r.cval;   wr = 1'b1; end
      ACT_ADD:  begin wval = op_a + op_b; wr = 1'b1; end
      ACT_SUB:  begin wval = op_a - op_b; wr = 1'b1; end
      ACT_MOVE: begin wval = op_a;        wr = 1'b1; end
      ACT_END:  ended = 1'b1;
      default:  ;
    endcase

    pc_nxt = take ? s1_r.target : pc_r + PC_WIDTH'(1);
    if (!ended && 32'(pc_nxt) >= 32'(prog_len_r)) begin
      ended = 1'b1;
    end
    if (ended) begin
      pc_nxt = '0;
    end
  end

  assign npc_ext = 32'(pc_nxt);
  assign wr_en   = s1_fire && wr && dst_in_range;
  assign waddr   = s1_r.dst[VAR_AW-1:0];

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
      pc_r       <= '0;
      s1_vld_r   <= 1'b0;
      vld_r      <= '0;
      fwd_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        prog_len_r <= cfg_wdata;
      end
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        pc_r      <= pc_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (wr_en) begin
        vld_r[waddr] <= 1'b1;
        fwd_vld_r    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (wr_en) begin
      fwd_idx_r  <= s1_r.dst;
      fwd_data_r <= wval;
    end
    if (s1_fire) begin
      out_pc_r    <= npc_ext[15:0];
      out_done_r  <= ended;
      out_taken_r <= take;
      out_wval_r  <= wval;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_next_pc       = out_pc_r;
  assign out_done_res      = out_done_r;
  assign out_taken         = out_taken_r;
  assign out_written_value = out_wval_r;

  // ------------------------------------------------------------ assertions
  a_written_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(waddr)])
    else $error("written variable not marked valid");

  a_done_pc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_next_pc == '0)
    else $error("finished run with non-zero next pc");

  a_done_resets_pc: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && ended |=> pc_r == '0)
    else $error("pc not returned to zero after run end");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_vld_r && !out_ready |-> !in_ready)
    else $error("input accepted while execute stage is stalled");

endmodule

`default_nettype wire
